// ----- design/mce_pkg.sv -----
// Shared types and constants for the coprocessor-0 exception unit.
// No dependencies; imported by every module of the block but mce_checker.
package mce_pkg;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_EXC    = 2'd2,
        MODE_RETIRE = 2'd3
    } t_mode;

    // Register numbers
    localparam logic [4:0] REG_INDEX    = 5'd0;
    localparam logic [4:0] REG_ENTRYLO0 = 5'd2;
    localparam logic [4:0] REG_ENTRYLO1 = 5'd3;
    localparam logic [4:0] REG_PAGEMASK = 5'd5;
    localparam logic [4:0] REG_WIRED    = 5'd6;
    localparam logic [4:0] REG_COUNT    = 5'd9;
    localparam logic [4:0] REG_ENTRYHI  = 5'd10;
    localparam logic [4:0] REG_COMPARE  = 5'd11;
    localparam logic [4:0] REG_STATUS   = 5'd12;
    localparam logic [4:0] REG_CAUSE    = 5'd13;
    localparam logic [4:0] REG_EPC      = 5'd14;
    localparam logic [4:0] REG_PRID     = 5'd15;
    localparam logic [4:0] REG_CONFIG   = 5'd16;

    localparam logic [31:0] PROC_ID      = 32'h0000_2e20;
    localparam logic [31:0] CONFIG_RESET = 32'h0000_0440;
    localparam logic [31:0] STATUS_RESET = 32'h0040_0004;

    // Status bit positions
    localparam int ST_IE  = 0;
    localparam int ST_EXL = 1;
    localparam int ST_ERL = 2;
    localparam int ST_EIE = 16;
    localparam int ST_BEV = 22;

    // Cause bit positions
    localparam int CA_IRQ0 = 10;
    localparam int CA_IRQ1 = 11;
    localparam int CA_BD   = 31;
    localparam logic [31:0] CODE_MASK = 32'h0000_007c;

    localparam logic [31:0] VEC_BASE_BEV  = 32'hbfc0_0200;
    localparam logic [31:0] VEC_BASE_NORM = 32'h8000_0000;
    localparam logic [31:0] VEC_OFS_INT   = 32'h0000_0200;
    localparam logic [31:0] VEC_OFS_EXC   = 32'h0000_0180;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic [4:0]  exc_code;
        logic [31:0] pc_value;
        logic        in_delay_slot;
        logic [11:0] retired_count;
        logic        irq_line0;
        logic        irq_line1;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        redirect;
        logic [31:0] next_pc;
    } t_result;

endpackage

// ----- design/mce_regfile.sv -----
// Coprocessor-0 register file with exception entry and block retirement.
// Depends on mce_pkg; one item is processed per i_fire.
module mce_regfile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mce_pkg::t_item   i_item,
    output mce_pkg::t_result o_result
);
    import mce_pkg::*;

    logic [31:0] r_index, r_lo0, r_lo1, r_pmask, r_wired, r_count;
    logic [31:0] r_ehi, r_compare, r_status, r_cause, r_epc, r_config;
    logic [31:0] n_index, n_lo0, n_lo1, n_pmask, n_wired, n_count;
    logic [31:0] n_ehi, n_compare, n_status, n_cause, n_epc, n_config;

    logic [31:0] rd_mux;
    logic [31:0] cause_irq;
    logic        take_exc;
    logic [4:0]  exc_code;
    logic        exc_delay;
    logic [31:0] cause_base;
    logic        int_enabled;
    logic        int_pending;

    always_comb begin
        case (i_item.reg_index)
            REG_INDEX:    rd_mux = r_index;
            REG_ENTRYLO0: rd_mux = r_lo0;
            REG_ENTRYLO1: rd_mux = r_lo1;
            REG_PAGEMASK: rd_mux = r_pmask;
            REG_WIRED:    rd_mux = r_wired;
            REG_COUNT:    rd_mux = r_count;
            REG_ENTRYHI:  rd_mux = r_ehi;
            REG_COMPARE:  rd_mux = r_compare;
            REG_STATUS:   rd_mux = r_status;
            REG_CAUSE:    rd_mux = r_cause;
            REG_EPC:      rd_mux = r_epc;
            REG_PRID:     rd_mux = PROC_ID;
            REG_CONFIG:   rd_mux = r_config;
            default:      rd_mux = '0;
        endcase
    end

    // Cause with the external interrupt levels loaded
    always_comb begin
        cause_irq          = r_cause;
        cause_irq[CA_IRQ0] = i_item.irq_line0;
        cause_irq[CA_IRQ1] = i_item.irq_line1;
    end

    assign int_enabled = r_status[ST_IE] && r_status[ST_EIE]
                      && !r_status[ST_EXL] && !r_status[ST_ERL];
    assign int_pending = (r_status[CA_IRQ0] && cause_irq[CA_IRQ0])
                      || (r_status[CA_IRQ1] && cause_irq[CA_IRQ1]);

    always_comb begin
        n_index   = r_index;
        n_lo0     = r_lo0;
        n_lo1     = r_lo1;
        n_pmask   = r_pmask;
        n_wired   = r_wired;
        n_count   = r_count;
        n_ehi     = r_ehi;
        n_compare = r_compare;
        n_status  = r_status;
        n_cause   = r_cause;
        n_epc     = r_epc;
        n_config  = r_config;

        take_exc   = 1'b0;
        exc_code   = i_item.exc_code;
        exc_delay  = i_item.in_delay_slot;
        cause_base = r_cause;

        o_result.read_data = '0;
        o_result.redirect  = 1'b0;
        o_result.next_pc   = i_item.pc_value;

        case (t_mode'(i_item.mode))
            MODE_READ: begin
                o_result.read_data = rd_mux;
            end
            MODE_WRITE: begin
                case (i_item.reg_index)
                    REG_INDEX:    n_index   = i_item.write_data;
                    REG_ENTRYLO0: n_lo0     = i_item.write_data;
                    REG_ENTRYLO1: n_lo1     = i_item.write_data;
                    REG_PAGEMASK: n_pmask   = i_item.write_data;
                    REG_WIRED:    n_wired   = i_item.write_data;
                    REG_COUNT:    n_count   = i_item.write_data;
                    REG_ENTRYHI:  n_ehi     = i_item.write_data;
                    REG_COMPARE:  n_compare = i_item.write_data;
                    REG_STATUS:   n_status  = i_item.write_data;
                    REG_CONFIG:   n_config  = i_item.write_data;
                    default:      ;
                endcase
            end
            MODE_EXC: begin
                take_exc = 1'b1;
            end
            MODE_RETIRE: begin
                cause_base = cause_irq;
                n_cause    = cause_irq;
                take_exc   = int_enabled && int_pending;
                exc_code   = '0;
                exc_delay  = 1'b0;
                n_count    = r_count + {20'd0, i_item.retired_count};
            end
            default: ;
        endcase

        if (take_exc) begin
            n_cause = (cause_base & ~CODE_MASK) | {25'd0, exc_code, 2'b00};
            if (!r_status[ST_EXL]) begin
                n_epc          = exc_delay ? (i_item.pc_value - 32'd4) : i_item.pc_value;
                n_cause[CA_BD] = exc_delay;
            end
            n_status[ST_EXL]  = 1'b1;
            o_result.redirect = 1'b1;
            o_result.next_pc  = (r_status[ST_BEV] ? VEC_BASE_BEV : VEC_BASE_NORM)
                              + ((exc_code == 5'd0) ? VEC_OFS_INT : VEC_OFS_EXC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_lo0     <= '0;
            r_lo1     <= '0;
            r_pmask   <= '0;
            r_wired   <= '0;
            r_count   <= '0;
            r_ehi     <= '0;
            r_compare <= '0;
            r_status  <= STATUS_RESET;
            r_cause   <= '0;
            r_epc     <= '0;
            r_config  <= CONFIG_RESET;
        end else if (i_fire) begin
            r_index   <= n_index;
            r_lo0     <= n_lo0;
            r_lo1     <= n_lo1;
            r_pmask   <= n_pmask;
            r_wired   <= n_wired;
            r_count   <= n_count;
            r_ehi     <= n_ehi;
            r_compare <= n_compare;
            r_status  <= n_status;
            r_cause   <= n_cause;
            r_epc     <= n_epc;
            r_config  <= n_config;
        end
    end

endmodule

// ----- design/mips_cop0_exception_unit.sv -----
// Top level of the coprocessor-0 exception unit: input register, register
// file stage, result register. Depends on mce_pkg and mce_regfile.
//
// One operation per transfer: register read, register write, exception
// entry, or block retirement with interrupt check and count update. The unit
// takes one transfer every clock cycle while the output is not stalled; an
// item passes the input register, then the result register, before its
// result is presented on the output, and operations act on the register
// state strictly in arrival order. The register update between the input
// and result registers sets this rate. Both channels use valid/ready; a
// result left waiting on the output does not stop the next input from being
// registered, and the pipeline stalls only once both the input register and
// the result register hold items. After reset, status reads 0x00400004 (BEV
// and ERL set), config 0x00000440, PRID 0x00002e20; all else is zero.
module mips_cop0_exception_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic [4:0]  i_exc_code,
    input  logic [31:0] i_pc_value,
    input  logic        i_in_delay_slot,
    input  logic [11:0] i_retired_count,
    input  logic        i_irq_line0,
    input  logic        i_irq_line1,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_redirect,
    output logic [31:0] o_next_pc
);
    import mce_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result proc_result;
    logic    proc_fire;
    logic    in_xfer;

    // Advance the held item when the result register is empty or draining
    assign proc_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_fire;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload: capture on every input transfer, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.mode          <= i_mode;
            r_item.reg_index     <= i_reg_index;
            r_item.write_data    <= i_write_data;
            r_item.exc_code      <= i_exc_code;
            r_item.pc_value      <= i_pc_value;
            r_item.in_delay_slot <= i_in_delay_slot;
            r_item.retired_count <= i_retired_count;
            r_item.irq_line0     <= i_irq_line0;
            r_item.irq_line1     <= i_irq_line1;
        end
    end

    mce_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_fire),
        .i_item   (r_item),
        .o_result (proc_result)
    );

    // Result register: load on advance, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_result <= proc_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_result.read_data;
    assign o_redirect  = r_result.redirect;
    assign o_next_pc   = r_result.next_pc;

endmodule

// ----- design/mce_checker.sv -----
// Port-level checks for the coprocessor-0 exception unit, bound to the top.
// Depends on nothing but the top-level ports.
module mce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_read_data,
    input logic        o_redirect,
    input logic [31:0] o_next_pc
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_next_pc)
            && $stable(o_redirect) && $stable(o_read_data))
        else $error("stalled result changed");

    // Accept input whenever no result is pending
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // A redirect always lands on one of the four vectors
    a_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_redirect |-> (o_next_pc == 32'hbfc0_0400)
            || (o_next_pc == 32'hbfc0_0380) || (o_next_pc == 32'h8000_0200)
            || (o_next_pc == 32'h8000_0180))
        else $error("redirect to a non-vector address");

    // A read result never carries a redirect
    a_read_no_redirect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_data != 32'd0) |-> !o_redirect)
        else $error("read data with redirect");

endmodule

bind mips_cop0_exception_unit mce_checker u_mce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_read_data (o_read_data),
    .o_redirect  (o_redirect),
    .o_next_pc   (o_next_pc)
);

// ----- dv/cop0_checker.sv -----
// Result checker for the coprocessor-0 exception unit: shadows the register
// state, predicts each result and compares it with the output channel.
// Depends on mce_pkg.
module cop0_checker
    import mce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic [4:0]  i_exc_code,
    input  logic [31:0] i_pc_value,
    input  logic        i_in_delay_slot,
    input  logic [11:0] i_retired_count,
    input  logic        i_irq_line0,
    input  logic        i_irq_line1,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_read_data,
    input  logic        i_redirect,
    input  logic [31:0] i_next_pc,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] idx_reg, lo0_reg, lo1_reg, pmask_reg, wired_reg, count_reg;
    logic [31:0] hi_reg, compare_reg, status_reg, cause_reg, epc_reg, config_reg;

    t_result outcome_q[$];
    int      errors = 0;

    function automatic logic [31:0] read_cop0(input logic [4:0] r);
        case (r)
            REG_INDEX:    return idx_reg;
            REG_ENTRYLO0: return lo0_reg;
            REG_ENTRYLO1: return lo1_reg;
            REG_PAGEMASK: return pmask_reg;
            REG_WIRED:    return wired_reg;
            REG_COUNT:    return count_reg;
            REG_ENTRYHI:  return hi_reg;
            REG_COMPARE:  return compare_reg;
            REG_STATUS:   return status_reg;
            REG_CAUSE:    return cause_reg;
            REG_EPC:      return epc_reg;
            REG_PRID:     return PROC_ID;
            REG_CONFIG:   return config_reg;
            default:      return 32'd0;
        endcase
    endfunction

    // Enter level-1 handling and return the vector address.
    function automatic logic [31:0] enter_vector(input logic [4:0] code,
                                                 input logic [31:0] pc,
                                                 input logic delay);
        logic [31:0] base;
        logic [31:0] ofs;
        ofs       = (code == 5'd0) ? VEC_OFS_INT : VEC_OFS_EXC;
        cause_reg = (cause_reg & ~CODE_MASK) | {25'd0, code, 2'b00};
        // epc and BD only move when not already in exception level
        if (!status_reg[ST_EXL]) begin
            epc_reg          = delay ? pc - 32'd4 : pc;
            cause_reg[CA_BD] = delay;
        end
        status_reg[ST_EXL] = 1'b1;
        base = status_reg[ST_BEV] ? VEC_BASE_BEV : VEC_BASE_NORM;
        return base + ofs;
    endfunction

    function automatic t_result cop0_execute(input t_item op);
        t_result res;
        logic    enabled;
        logic    pending;
        res.read_data = 32'd0;
        res.redirect  = 1'b0;
        res.next_pc   = op.pc_value;
        case (t_mode'(op.mode))
            MODE_READ: res.read_data = read_cop0(op.reg_index);
            MODE_WRITE: begin
                case (op.reg_index)
                    REG_INDEX:    idx_reg     = op.write_data;
                    REG_ENTRYLO0: lo0_reg     = op.write_data;
                    REG_ENTRYLO1: lo1_reg     = op.write_data;
                    REG_PAGEMASK: pmask_reg   = op.write_data;
                    REG_WIRED:    wired_reg   = op.write_data;
                    REG_COUNT:    count_reg   = op.write_data;
                    REG_ENTRYHI:  hi_reg      = op.write_data;
                    REG_COMPARE:  compare_reg = op.write_data;
                    REG_STATUS:   status_reg  = op.write_data;
                    REG_CONFIG:   config_reg  = op.write_data;
                    default: ;
                endcase
            end
            MODE_EXC: begin
                res.next_pc  = enter_vector(op.exc_code, op.pc_value, op.in_delay_slot);
                res.redirect = 1'b1;
            end
            default: begin
                cause_reg[CA_IRQ0] = op.irq_line0;
                cause_reg[CA_IRQ1] = op.irq_line1;
                enabled = status_reg[ST_IE] && status_reg[ST_EIE]
                       && !status_reg[ST_EXL] && !status_reg[ST_ERL];
                pending = (status_reg[CA_IRQ0] && cause_reg[CA_IRQ0])
                       || (status_reg[CA_IRQ1] && cause_reg[CA_IRQ1]);
                if (enabled && pending) begin
                    res.next_pc  = enter_vector(5'd0, op.pc_value, 1'b0);
                    res.redirect = 1'b1;
                end
                count_reg = count_reg + {20'd0, op.retired_count};
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        if (errors < 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_item   op;
        t_result want;
        if (!i_rst_n) begin
            idx_reg     = '0;
            lo0_reg     = '0;
            lo1_reg     = '0;
            pmask_reg   = '0;
            wired_reg   = '0;
            count_reg   = '0;
            hi_reg      = '0;
            compare_reg = '0;
            cause_reg   = '0;
            epc_reg     = '0;
            status_reg  = STATUS_RESET;
            config_reg  = CONFIG_RESET;
            outcome_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                op.mode          = i_mode;
                op.reg_index     = i_reg_index;
                op.write_data    = i_write_data;
                op.exc_code      = i_exc_code;
                op.pc_value      = i_pc_value;
                op.in_delay_slot = i_in_delay_slot;
                op.retired_count = i_retired_count;
                op.irq_line0     = i_irq_line0;
                op.irq_line1     = i_irq_line1;
                outcome_q.push_back(cop0_execute(op));
            end
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    if (errors < 10)
                        $display("result transfer with nothing outstanding: %h %b %h",
                                 i_read_data, i_redirect, i_next_pc);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, i_read_data);
                    if (i_redirect !== want.redirect)
                        report_mismatch("redirect", {31'd0, want.redirect},
                                        {31'd0, i_redirect});
                    if (i_next_pc !== want.next_pc)
                        report_mismatch("next_pc", want.next_pc, i_next_pc);
                end
            end
        end
        // publish with nonblocking updates so the stimulus side sees
        // pre-edge values only
        o_pending    <= outcome_q.size();
        o_fail_count <= errors;
    end

endmodule

// ----- dv/testbench.sv -----
// Top of the coprocessor-0 exception unit test: drives directed and random
// operations in bursts, stalls the result side, and reports the verdict.
// Depends on mce_pkg, mips_cop0_exception_unit and cop0_checker.
module testbench;
    import mce_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_OPS   = 900;
    localparam int DRAIN_CYCLES = 10;

    // indices with no register behind them
    localparam logic [4:0] REG_UNUSED_LO = 5'd1;
    localparam logic [4:0] REG_UNUSED_HI = 5'd31;

    // IE, EIE and both interrupt mask bits, EXL/ERL/BEV clear
    localparam logic [31:0] INT_ENABLE_BOTH = 32'h0001_0c01;
    // same, with only the irq0 mask bit
    localparam logic [31:0] INT_ENABLE_IRQ0 = 32'h0001_0401;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  mode          = MODE_READ;
    logic [4:0]  reg_index     = '0;
    logic [31:0] write_data    = '0;
    logic [4:0]  exc_code      = '0;
    logic [31:0] pc_value      = '0;
    logic        in_delay_slot = 1'b0;
    logic [11:0] retired_count = '0;
    logic        irq_line0     = 1'b0;
    logic        irq_line1     = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [31:0] read_data;
    logic        redirect;
    logic [31:0] next_pc;

    int fail_count;
    int pending;
    int burst_left = 1;
    int cycles     = 0;

    logic [4:0] mapped_regs [13] = '{
        REG_INDEX, REG_ENTRYLO0, REG_ENTRYLO1, REG_PAGEMASK, REG_WIRED,
        REG_COUNT, REG_ENTRYHI, REG_COMPARE, REG_STATUS, REG_CAUSE,
        REG_EPC, REG_PRID, REG_CONFIG
    };

    mips_cop0_exception_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (mode),
        .i_reg_index     (reg_index),
        .i_write_data    (write_data),
        .i_exc_code      (exc_code),
        .i_pc_value      (pc_value),
        .i_in_delay_slot (in_delay_slot),
        .i_retired_count (retired_count),
        .i_irq_line0     (irq_line0),
        .i_irq_line1     (irq_line1),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_read_data     (read_data),
        .o_redirect      (redirect),
        .o_next_pc       (next_pc)
    );

    cop0_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_mode          (mode),
        .i_reg_index     (reg_index),
        .i_write_data    (write_data),
        .i_exc_code      (exc_code),
        .i_pc_value      (pc_value),
        .i_in_delay_slot (in_delay_slot),
        .i_retired_count (retired_count),
        .i_irq_line0     (irq_line0),
        .i_irq_line1     (irq_line1),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_read_data     (read_data),
        .i_redirect      (redirect),
        .i_next_pc       (next_pc),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Result side: switch between stall styles after a random span.
    initial begin
        int style;
        int span;
        int tick;
        style = 0;
        span  = 0;
        tick  = 0;
        forever begin
            @(posedge clk);
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(20, 200);
            end
            span--;
            tick++;
            case (style)
                0: out_ready <= 1'b1;                          // no stalls
                1: out_ready <= ($urandom_range(0, 1) == 1);   // coin flip
                2: out_ready <= ($urandom_range(0, 3) == 0);   // heavy stall
                default: out_ready <= (tick % 3 != 0);         // periodic
            endcase
        end
    end

    // Give up if the run hangs.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Present one operation and hold it until the transfer; close the burst
    // with a random gap when it runs out.
    task automatic transfer_op(input t_item op);
        in_valid      <= 1'b1;
        mode          <= op.mode;
        reg_index     <= op.reg_index;
        write_data    <= op.write_data;
        exc_code      <= op.exc_code;
        pc_value      <= op.pc_value;
        in_delay_slot <= op.in_delay_slot;
        retired_count <= op.retired_count;
        irq_line0     <= op.irq_line0;
        irq_line1     <= op.irq_line1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_op(input t_mode m, input logic [4:0] idx,
                           input logic [31:0] wdata, input logic [4:0] code,
                           input logic [31:0] pc, input logic ds,
                           input logic [11:0] ret, input logic q0, input logic q1);
        t_item op;
        op.mode          = m;
        op.reg_index     = idx;
        op.write_data    = wdata;
        op.exc_code      = code;
        op.pc_value      = pc;
        op.in_delay_slot = ds;
        op.retired_count = ret;
        op.irq_line0     = q0;
        op.irq_line1     = q1;
        transfer_op(op);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        // let the count published at the last transfer edge settle first
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        t_item op;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, including the fixed id and an unmapped index
        send_op(MODE_READ, REG_STATUS, '0, '0, 32'h0000_0000, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_READ, REG_CONFIG, '1, '1, 32'hffff_ffff, 1'b1, '1, 1'b1, 1'b1);
        send_op(MODE_READ, REG_PRID, '0, '0, 32'h1234_5678, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_READ, REG_UNUSED_LO, '0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);

        // Writes that must be dropped: read-only and unmapped registers
        send_op(MODE_WRITE, REG_CAUSE, '1, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_WRITE, REG_EPC, '1, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_WRITE, REG_PRID, '1, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_WRITE, REG_UNUSED_HI, '1, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_READ, REG_CAUSE, '0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_READ, REG_EPC, '0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_READ, REG_UNUSED_HI, '0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);

        // Exception in a delay slot at pc zero: epc wraps, BD set, BEV vector
        send_op(MODE_EXC, REG_INDEX, '0, 5'd31, 32'h0000_0000, 1'b1, '0, 1'b0, 1'b0);
        // Second exception with EXL already set: epc and BD stay
        send_op(MODE_EXC, REG_INDEX, '0, 5'd0, 32'hffff_ffff, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_READ, REG_CAUSE, '0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_READ, REG_EPC, '0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);

        // Count wraps on a maximal retire; EXL blocks the interrupt
        send_op(MODE_WRITE, REG_COUNT, '1, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_RETIRE, REG_INDEX, '0, '0, 32'h0000_1000, 1'b0, '1, 1'b1, 1'b1);
        send_op(MODE_READ, REG_COUNT, '0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);

        // Enable interrupts with BEV clear, then take one on irq0
        send_op(MODE_WRITE, REG_STATUS, INT_ENABLE_BOTH, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_RETIRE, REG_INDEX, '0, '0, 32'h1234_5678, 1'b1, 12'd1, 1'b1, 1'b0);
        // Again on irq1 alone
        send_op(MODE_WRITE, REG_STATUS, INT_ENABLE_BOTH, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_RETIRE, REG_INDEX, '0, '0, 32'h8765_4320, 1'b0, '0, 1'b0, 1'b1);
        // Masked line: irq1 pending but only irq0 enabled, no redirect
        send_op(MODE_WRITE, REG_STATUS, INT_ENABLE_IRQ0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);
        send_op(MODE_RETIRE, REG_INDEX, '0, '0, 32'hdead_beec, 1'b0, 12'd7, 1'b0, 1'b1);
        send_op(MODE_READ, REG_CAUSE, '0, '0, 32'h0, 1'b0, '0, 1'b0, 1'b0);

        drain_results();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            int roll;
            roll             = $urandom_range(0, 99);
            op.write_data    = $urandom();
            op.exc_code      = $urandom_range(0, 31);
            op.pc_value      = $urandom();
            op.in_delay_slot = $urandom_range(0, 1);
            op.retired_count = $urandom_range(0, 4095);
            op.irq_line0     = $urandom_range(0, 1);
            op.irq_line1     = $urandom_range(0, 1);
            op.reg_index     = ($urandom_range(0, 9) < 7)
                             ? mapped_regs[$urandom_range(0, 12)]
                             : 5'($urandom_range(0, 31));
            if (roll < 30) begin
                op.mode = MODE_READ;
            end else if (roll < 60) begin
                op.mode = MODE_WRITE;
                if ($urandom_range(0, 99) < 35)
                    op.reg_index = REG_STATUS;
                // arm interrupts most of the time so retires can redirect
                if (op.reg_index == REG_STATUS && $urandom_range(0, 3) != 0) begin
                    op.write_data[ST_IE]  = 1'b1;
                    op.write_data[ST_EIE] = 1'b1;
                    op.write_data[ST_EXL] = 1'b0;
                    op.write_data[ST_ERL] = 1'b0;
                    if (!op.write_data[CA_IRQ0] && !op.write_data[CA_IRQ1])
                        op.write_data[CA_IRQ0 + $urandom_range(0, 1)] = 1'b1;
                end
                // push the counter near its wrap point now and then
                if (op.reg_index == REG_COUNT && $urandom_range(0, 1) == 1)
                    op.write_data[31:12] = '1;
            end else if (roll < 75) begin
                op.mode = MODE_EXC;
            end else begin
                op.mode = MODE_RETIRE;
                if (!op.irq_line0 && !op.irq_line1 && $urandom_range(0, 9) < 7)
                    op.irq_line1 = 1'b1;
            end
            transfer_op(op);
            if (n == RANDOM_OPS / 2)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
